### design/vss_pkg.sv
// Shared types, constants and helper functions of the voltmeter display scan.
package vss_pkg;

	localparam int SAMPLE_BITS_DEFAULT = 10;
	localparam int FS_BITS = 14;
	localparam int CFG_INDEX_BITS = 2;
	localparam int QUEUE_DEPTH = 2;
	localparam int DIGIT_BASE = 10;

	localparam logic [CFG_INDEX_BITS-1:0] REG_FULL_SCALE = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_CHANGE_THRESHOLD = 2'd1;

	localparam logic [FS_BITS-1:0] FULL_SCALE_RESET = 14'd500;
	localparam logic [FS_BITS-1:0] THRESHOLD_RESET = 14'd8;

	localparam logic [3:0] SEL_ONES = 4'h7;
	localparam logic [3:0] SEL_TENS = 4'hB;
	localparam logic [3:0] SEL_HUNDREDS = 4'hD;
	localparam logic [3:0] SEL_THOUSANDS = 4'hE;

	localparam int DIGIT_ONES = 0;
	localparam int DIGIT_TENS = 1;
	localparam int DIGIT_HUNDREDS = 2;
	localparam int DIGIT_THOUSANDS = 3;

	localparam logic [FS_BITS-1:0] DIV10_MUL = 14'd6554;

	typedef logic [FS_BITS-1:0] value_t;
	typedef logic [3:0] digit_t;

	typedef struct packed {
		value_t full_scale;
		value_t change_threshold;
	} cfg_regs_t;

	typedef struct packed {
		value_t reading;
		digit_t [3:0] digits;
	} queue_entry_t;

	typedef enum logic [1:0] {
		FRAME_TENS,
		FRAME_HUNDREDS,
		FRAME_THOUSANDS,
		FRAME_ONES
	} frame_t;

	// exact for every 14-bit value
	function automatic value_t div10(input value_t v);
		logic [2*FS_BITS-1:0] p;
		p = (2*FS_BITS)'(v) * (2*FS_BITS)'(DIV10_MUL);
		return value_t'(p[2*FS_BITS-1:16]);
	endfunction

	function automatic digit_t rem10(input value_t v, input value_t q);
		value_t t;
		t = v - ((q << 3) + (q << 1));
		return t[3:0];
	endfunction

	function automatic logic [7:0] seg_code(input digit_t d);
		logic [7:0] s;
		case (d)
			4'd0: s = 8'hC0;
			4'd1: s = 8'hF9;
			4'd2: s = 8'hA4;
			4'd3: s = 8'hB0;
			4'd4: s = 8'h99;
			4'd5: s = 8'h92;
			4'd6: s = 8'h82;
			4'd7: s = 8'hF8;
			4'd8: s = 8'h80;
			4'd9: s = 8'h90;
			default: s = 8'hFF;
		endcase
		return s;
	endfunction

endpackage

### design/vss_ifs.sv
// Handshake interfaces for the sample, frame and configuration channels.
interface vss_sample_if #(parameter int SAMPLE_BITS = vss_pkg::SAMPLE_BITS_DEFAULT);
	logic valid;
	logic ready;
	logic [SAMPLE_BITS-1:0] adc_sample;

	modport source (output valid, output adc_sample, input ready);
	modport sink (input valid, input adc_sample, output ready);
endinterface

interface vss_frame_if;
	logic valid;
	logic ready;
	logic [7:0] segment_byte;
	logic [3:0] digit_select;
	logic point_pin;
	logic last_frame;

	modport source (output valid, output segment_byte, output digit_select,
		output point_pin, output last_frame, input ready);
	modport sink (input valid, input segment_byte, input digit_select,
		input point_pin, input last_frame, output ready);
endinterface

interface vss_cfg_if;
	logic valid;
	logic ready;
	logic [vss_pkg::CFG_INDEX_BITS-1:0] reg_index;
	logic [vss_pkg::FS_BITS-1:0] write_data;

	modport source (output valid, output reg_index, output write_data, input ready);
	modport sink (input valid, input reg_index, input write_data, output ready);
endinterface

### design/voltmeter_seven_segment_scan.sv
// Top level of the voltmeter display scan: configuration registers and the three parts.
//
// channel  direction  handshake            payload
// sample   in         valid/ready          adc_sample
// frame    out        valid/ready          segment_byte, digit_select, point_pin, last_frame
// cfg      in         valid/ready (ready=1) reg_index, write_data
//
// Each item gives four frames, paced by the back end's frame counter: one per cycle while
// an item is queued and the output is not stalled; the queue pops on the ones frame.
// A sample passes the 8-stage front pipeline, the queue and the frame output registers.
// Reset clears the held value to zero and loads the register defaults; no clearing pass.
// A stalled frame output holds the queue; a full queue stalls the front and sample.ready.
module voltmeter_seven_segment_scan #(
	parameter int SAMPLE_BITS = vss_pkg::SAMPLE_BITS_DEFAULT
) (
	input logic clk,
	input logic arst_n,
	vss_sample_if.sink sample,
	vss_frame_if.source frame,
	vss_cfg_if.sink cfg
);

	vss_pkg::cfg_regs_t cfg_q;
	logic push_valid, push_ready;
	logic pop_valid, pop_ready;
	vss_pkg::queue_entry_t push_data, pop_data;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.full_scale <= vss_pkg::FULL_SCALE_RESET;
			cfg_q.change_threshold <= vss_pkg::THRESHOLD_RESET;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.reg_index)
				vss_pkg::REG_FULL_SCALE: cfg_q.full_scale <= cfg.write_data;
				vss_pkg::REG_CHANGE_THRESHOLD: cfg_q.change_threshold <= cfg.write_data;
				default: ;
			endcase
		end
	end

	vss_front #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.sample(sample),
		.full_scale(cfg_q.full_scale),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data(push_data)
	);

	vss_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data(push_data),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_data(pop_data)
	);

	vss_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_data(pop_data),
		.change_threshold(cfg_q.change_threshold),
		.frame(frame)
	);

endmodule

### design/vss_front.sv
// Front pipeline: scales each sample to a reading and splits it into decimal digits.
module vss_front #(
	parameter int SAMPLE_BITS = vss_pkg::SAMPLE_BITS_DEFAULT
) (
	input logic clk,
	input logic arst_n,
	vss_sample_if.sink sample,
	input vss_pkg::value_t full_scale,
	output logic push_valid,
	input logic push_ready,
	output vss_pkg::queue_entry_t push_data
);

	localparam int PW = SAMPLE_BITS + vss_pkg::FS_BITS;
	localparam int R1W = ((vss_pkg::FS_BITS > SAMPLE_BITS) ? vss_pkg::FS_BITS : SAMPLE_BITS) + 1;
	localparam int R2W = SAMPLE_BITS + 1;
	localparam logic [R2W-1:0] MAX_CODE = R2W'((1 << SAMPLE_BITS) - 1);
	localparam logic [R2W-1:0] TWICE_MAX = R2W'(2 * ((1 << SAMPLE_BITS) - 1));

	logic en;
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6, valid_s7, valid_s8;

	logic [SAMPLE_BITS-1:0] sample_s1;
	logic [PW-1:0] prod_s2;
	vss_pkg::value_t quot_s3, quot_s4;
	logic [R1W-1:0] rem_s3;
	logic [R2W-1:0] rem_s4;
	vss_pkg::value_t reading_s5, reading_s6, reading_s7, reading_s8;
	vss_pkg::value_t part_s6, part_s7, part_s8;
	vss_pkg::digit_t ones_s6, ones_s7, ones_s8;
	vss_pkg::digit_t tens_s7, tens_s8;
	vss_pkg::digit_t hundreds_s8;

	vss_pkg::value_t div_5, div_6, div_7;
	logic [1:0] corr_4;
	vss_pkg::value_t thousands_8;

	assign en = !valid_s8 || push_ready;
	assign sample.ready = en;

	always_comb begin
		if (rem_s4 >= TWICE_MAX) begin
			corr_4 = 2'd2;
		end else if (rem_s4 >= MAX_CODE) begin
			corr_4 = 2'd1;
		end else begin
			corr_4 = 2'd0;
		end
		div_5 = vss_pkg::div10(reading_s5);
		div_6 = vss_pkg::div10(part_s6);
		div_7 = vss_pkg::div10(part_s7);
		if (part_s8 >= vss_pkg::value_t'(vss_pkg::DIGIT_BASE)) begin
			thousands_8 = part_s8 - vss_pkg::value_t'(vss_pkg::DIGIT_BASE);
		end else begin
			thousands_8 = part_s8;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
			valid_s8 <= 1'b0;
		end else if (en) begin
			valid_s1 <= sample.valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
			valid_s8 <= valid_s7;
		end
	end

	// fold by 2^n - 1: x = a*2^n + b gives a plus (a + b) over the same divisor
	always_ff @(posedge clk) begin
		if (en) begin
			sample_s1 <= sample.adc_sample;
			prod_s2 <= PW'(sample_s1) * PW'(full_scale);
			quot_s3 <= vss_pkg::value_t'(prod_s2[PW-1:SAMPLE_BITS]);
			rem_s3 <= R1W'(prod_s2[PW-1:SAMPLE_BITS]) + R1W'(prod_s2[SAMPLE_BITS-1:0]);
			quot_s4 <= quot_s3 + vss_pkg::value_t'(rem_s3[R1W-1:SAMPLE_BITS]);
			rem_s4 <= R2W'(rem_s3[R1W-1:SAMPLE_BITS]) + R2W'(rem_s3[SAMPLE_BITS-1:0]);
			reading_s5 <= quot_s4 + vss_pkg::value_t'(corr_4);
			reading_s6 <= reading_s5;
			part_s6 <= div_5;
			ones_s6 <= vss_pkg::rem10(reading_s5, div_5);
			reading_s7 <= reading_s6;
			part_s7 <= div_6;
			ones_s7 <= ones_s6;
			tens_s7 <= vss_pkg::rem10(part_s6, div_6);
			reading_s8 <= reading_s7;
			part_s8 <= div_7;
			ones_s8 <= ones_s7;
			tens_s8 <= tens_s7;
			hundreds_s8 <= vss_pkg::rem10(part_s7, div_7);
		end
	end

	always_comb begin
		push_valid = valid_s8;
		push_data.reading = reading_s8;
		push_data.digits[vss_pkg::DIGIT_ONES] = ones_s8;
		push_data.digits[vss_pkg::DIGIT_TENS] = tens_s8;
		push_data.digits[vss_pkg::DIGIT_HUNDREDS] = hundreds_s8;
		push_data.digits[vss_pkg::DIGIT_THOUSANDS] = thousands_8[3:0];
	end

endmodule

### design/vss_queue.sv
// Short queue of scaled readings between the front pipeline and the scan back end.
module vss_queue (
	input logic clk,
	input logic arst_n,
	input logic push_valid,
	output logic push_ready,
	input vss_pkg::queue_entry_t push_data,
	output logic pop_valid,
	input logic pop_ready,
	output vss_pkg::queue_entry_t pop_data
);

	localparam int DEPTH = vss_pkg::QUEUE_DEPTH;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	vss_pkg::queue_entry_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic push, pop;

	assign push_ready = count_q != CNT_W'(DEPTH);
	assign pop_valid = count_q != '0;
	assign push = push_valid && push_ready;
	assign pop = pop_valid && pop_ready;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### design/vss_back.sv
// Scan back end: four frames of held value per item, then a thresholded update.
module vss_back (
	input logic clk,
	input logic arst_n,
	input logic pop_valid,
	output logic pop_ready,
	input vss_pkg::queue_entry_t pop_data,
	input vss_pkg::value_t change_threshold,
	vss_frame_if.source frame
);

	vss_pkg::frame_t frame_q, frame_d;
	vss_pkg::value_t held_value_q;
	vss_pkg::digit_t [3:0] held_digits_q;
	logic out_valid_q;
	logic [7:0] seg_q;
	logic [3:0] sel_q;
	logic point_q;
	logic last_q;

	logic load;
	vss_pkg::digit_t digit;
	logic [3:0] sel;
	logic point;
	logic last;
	vss_pkg::value_t diff;

	assign frame.valid = out_valid_q;
	assign frame.segment_byte = seg_q;
	assign frame.digit_select = sel_q;
	assign frame.point_pin = point_q;
	assign frame.last_frame = last_q;

	always_comb begin
		load = pop_valid && (!out_valid_q || frame.ready);
		case (frame_q)
			vss_pkg::FRAME_TENS: begin
				digit = held_digits_q[vss_pkg::DIGIT_TENS];
				sel = vss_pkg::SEL_TENS;
				point = 1'b1;
				last = 1'b0;
				frame_d = vss_pkg::FRAME_HUNDREDS;
			end
			vss_pkg::FRAME_HUNDREDS: begin
				digit = held_digits_q[vss_pkg::DIGIT_HUNDREDS];
				sel = vss_pkg::SEL_HUNDREDS;
				point = 1'b0;
				last = 1'b0;
				frame_d = vss_pkg::FRAME_THOUSANDS;
			end
			vss_pkg::FRAME_THOUSANDS: begin
				digit = held_digits_q[vss_pkg::DIGIT_THOUSANDS];
				sel = vss_pkg::SEL_THOUSANDS;
				point = 1'b1;
				last = 1'b0;
				frame_d = vss_pkg::FRAME_ONES;
			end
			vss_pkg::FRAME_ONES: begin
				digit = held_digits_q[vss_pkg::DIGIT_ONES];
				sel = vss_pkg::SEL_ONES;
				point = 1'b1;
				last = 1'b1;
				frame_d = vss_pkg::FRAME_TENS;
			end
			default: begin
				digit = held_digits_q[vss_pkg::DIGIT_TENS];
				sel = vss_pkg::SEL_TENS;
				point = 1'b1;
				last = 1'b0;
				frame_d = vss_pkg::FRAME_TENS;
			end
		endcase
		pop_ready = load && last;
		if (pop_data.reading >= held_value_q) begin
			diff = pop_data.reading - held_value_q;
		end else begin
			diff = held_value_q - pop_data.reading;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_q <= vss_pkg::FRAME_TENS;
		end else if (load) begin
			frame_q <= frame_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			held_value_q <= '0;
			held_digits_q <= '0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (frame.ready) begin
				out_valid_q <= 1'b0;
			end
			if (pop_ready && (diff >= change_threshold)) begin
				held_value_q <= pop_data.reading;
				held_digits_q <= pop_data.digits;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			seg_q <= vss_pkg::seg_code(digit);
			sel_q <= sel;
			point_q <= point;
			last_q <= last;
		end
	end

`ifndef SYNTHESIS
	a_pop_on_ones: assert property (@(posedge clk) disable iff (!arst_n)
		pop_ready |-> frame_q == vss_pkg::FRAME_ONES)
		else $error("queue popped before the ones frame");
	a_held_moves_on_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(held_value_q != $past(held_value_q)) |-> $past(pop_ready))
		else $error("held value changed without a finished item");
	a_point_on_hundreds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ((sel_q == vss_pkg::SEL_HUNDREDS) == !point_q))
		else $error("decimal point off the hundreds digit");
	a_digits_decimal: assert property (@(posedge clk) disable iff (!arst_n)
		held_digits_q[0] < 4'd10 && held_digits_q[1] < 4'd10 &&
		held_digits_q[2] < 4'd10 && held_digits_q[3] < 4'd10)
		else $error("held digit out of decimal range");
`endif

endmodule

### bench/voltmeter_seven_segment_scan_test.sv
`timescale 1ns / 1ps
// Self-checking bench of the voltmeter scan: predicted scan frames checked against the block.
module voltmeter_seven_segment_scan_test;

	localparam int QUIET_LIMIT = 4000;
	localparam int PHASE_COUNT = 8;
	localparam int PHASE_ITEMS = 36;
	localparam int SETTLE_CYCLES = 16;
	localparam int MAX_CODE = 1023;
	localparam logic [vss_pkg::CFG_INDEX_BITS-1:0] REG_SPARE_LOW = 2'd2;
	localparam logic [vss_pkg::CFG_INDEX_BITS-1:0] REG_SPARE_HIGH = 2'd3;

	typedef struct packed {
		logic [7:0] segment_byte;
		logic [3:0] digit_select;
		logic point_pin;
		logic last_frame;
	} scan_frame_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic sample_valid = 1'b0;
	logic [9:0] sample_data = '0;
	logic frame_ready = 1'b0;
	logic cfg_valid = 1'b0;
	logic [vss_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
	vss_pkg::value_t cfg_data = '0;

	int send_gap_pct = 0;
	int stall_pct = 0;
	int error_count = 0;
	int quiet_cycles = 0;

	logic [9:0] pending_samples[$];
	scan_frame_t expected_frames[$];

	vss_pkg::value_t shown_value = '0;
	vss_pkg::value_t scale_setting = vss_pkg::FULL_SCALE_RESET;
	vss_pkg::value_t threshold_setting = vss_pkg::THRESHOLD_RESET;

	logic [7:0] digit_segments [10] = '{8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99,
		8'h92, 8'h82, 8'hF8, 8'h80, 8'h90};

	vss_sample_if #(.SAMPLE_BITS(10)) sample_ch();
	vss_frame_if frame_ch();
	vss_cfg_if cfg_ch();

	assign sample_ch.valid = sample_valid;
	assign sample_ch.adc_sample = sample_data;
	assign frame_ch.ready = frame_ready;
	assign cfg_ch.valid = cfg_valid;
	assign cfg_ch.reg_index = cfg_index;
	assign cfg_ch.write_data = cfg_data;

	voltmeter_seven_segment_scan #(.SAMPLE_BITS(10)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.sample(sample_ch),
		.frame(frame_ch),
		.cfg(cfg_ch)
	);

	always #5 clk = ~clk;

	function automatic void predict_frames(input logic [9:0] adc);
		int v;
		int reading;
		int diff;
		v = int'(shown_value);
		expected_frames.push_back(scan_frame_t'{digit_segments[(v / 10) % 10],
			vss_pkg::SEL_TENS, 1'b1, 1'b0});
		expected_frames.push_back(scan_frame_t'{digit_segments[(v / 100) % 10],
			vss_pkg::SEL_HUNDREDS, 1'b0, 1'b0});
		expected_frames.push_back(scan_frame_t'{digit_segments[(v / 1000) % 10],
			vss_pkg::SEL_THOUSANDS, 1'b1, 1'b0});
		expected_frames.push_back(scan_frame_t'{digit_segments[v % 10],
			vss_pkg::SEL_ONES, 1'b1, 1'b1});
		reading = ((int'(adc) * int'(scale_setting)) / MAX_CODE) & 32'h3FFF;
		diff = (reading >= v) ? reading - v : v - reading;
		if (diff >= int'(threshold_setting))
			shown_value = vss_pkg::value_t'(reading);
	endfunction

	task automatic report_field(input string label, input int want, input int got);
		if (want != got) begin
			error_count++;
			$display("%0t: %s expected %0h got %0h", $time, label, want, got);
		end
	endtask

	task automatic write_reg(input logic [vss_pkg::CFG_INDEX_BITS-1:0] idx,
			input vss_pkg::value_t data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		cfg_valid <= 1'b0;
		if (idx == vss_pkg::REG_FULL_SCALE)
			scale_setting = data;
		else if (idx == vss_pkg::REG_CHANGE_THRESHOLD)
			threshold_setting = data;
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending_samples.size() != 0 || sample_valid || expected_frames.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	always @(posedge clk) begin : drive_samples
		logic next_valid;
		logic [9:0] next_sample;
		if (arst_n) begin
			next_valid = sample_valid;
			next_sample = sample_data;
			if (sample_valid && sample_ch.ready) begin
				predict_frames(sample_data);
				next_valid = 1'b0;
			end
			if (!next_valid && pending_samples.size() != 0 &&
					int'($urandom_range(99)) >= send_gap_pct) begin
				next_valid = 1'b1;
				next_sample = pending_samples.pop_front();
			end
			sample_valid <= next_valid;
			sample_data <= next_sample;
		end
	end

	always @(posedge clk) begin : check_frames
		scan_frame_t want;
		if (arst_n) begin
			if (frame_ch.valid && frame_ready) begin
				if (expected_frames.size() == 0) begin
					error_count++;
					$display("%0t: frame expected none got seg %h sel %h dp %b last %b",
						$time, frame_ch.segment_byte, frame_ch.digit_select,
						frame_ch.point_pin, frame_ch.last_frame);
				end else begin
					want = expected_frames.pop_front();
					report_field("segment_byte", int'(want.segment_byte),
						int'(frame_ch.segment_byte));
					report_field("digit_select", int'(want.digit_select),
						int'(frame_ch.digit_select));
					report_field("point_pin", int'(want.point_pin), int'(frame_ch.point_pin));
					report_field("last_frame", int'(want.last_frame), int'(frame_ch.last_frame));
				end
			end
			frame_ready <= (int'($urandom_range(99)) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (sample_valid && sample_ch.ready) || (frame_ch.valid && frame_ready) ||
				(cfg_valid && cfg_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		int phase_scale [PHASE_COUNT];
		int phase_threshold [PHASE_COUNT];
		int directed [12];
		int edge_codes [6];
		int pick;
		int w;
		phase_scale = '{1023, 1, 9999, 16383, 0, 0, 5000, 9999};
		phase_threshold = '{0, 0, 9999, 0, 0, 0, 16383, 1};
		directed = '{0, 1023, 1023, 0, 1, 2, 16, 17, 1022, 512, 1023, 0};
		edge_codes = '{0, 1, 511, 512, 1022, 1023};
		phase_scale[5] = int'($urandom_range(9999, 1));
		phase_threshold[5] = int'($urandom_range(40));
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		foreach (directed[i])
			pending_samples.push_back(10'(directed[i]));
		wait_drained();
		for (int p = 0; p < PHASE_COUNT; p++) begin
			if (p == 4) begin
				write_reg(REG_SPARE_LOW, vss_pkg::value_t'($urandom));
				write_reg(REG_SPARE_HIGH, vss_pkg::value_t'($urandom));
			end
			write_reg(vss_pkg::REG_FULL_SCALE, vss_pkg::value_t'(phase_scale[p]));
			write_reg(vss_pkg::REG_CHANGE_THRESHOLD, vss_pkg::value_t'(phase_threshold[p]));
			case (p % 4)
				0: begin
					send_gap_pct = 0;
					stall_pct = 0;
				end
				1: begin
					send_gap_pct = 50;
					stall_pct = 0;
				end
				2: begin
					send_gap_pct = 0;
					stall_pct = 50;
				end
				default: begin
					send_gap_pct = 8;
					stall_pct = 8;
				end
			endcase
			w = int'($urandom_range(MAX_CODE));
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				pick = int'($urandom_range(99));
				if (pick < 15)
					w = edge_codes[$urandom_range(5)];
				else if (pick < 45)
					w = w + int'($urandom_range(40)) - 20;
				else
					w = int'($urandom_range(MAX_CODE));
				if (w < 0)
					w = 0;
				if (w > MAX_CODE)
					w = MAX_CODE;
				pending_samples.push_back(10'(w));
			end
			wait_drained();
		end
		if (error_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
